// ----- hdl/assert_macros.svh -----
// shared assertion macros for the moving average block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge out of reset
`define CMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cma_pkg.sv -----
`timescale 1ns / 1ps

package cma_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int HALF_W      = 5;
  localparam int MAX_HALF    = 31;
  localparam int HALF_RESET  = 2;
  localparam int RING_DEPTH  = 64;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int SEEN_W      = RING_AW;
  localparam int COUNT_W     = RING_AW + 1;
  localparam int SUM_W       = SAMPLE_W + RING_AW;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [HALF_W-1:0]          half_t;
  typedef logic [SEEN_W-1:0]          seen_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [RING_AW-1:0]         ring_addr_t;

  // saturation point of the per-record sample count
  localparam seen_t SEEN_MAX = '1;

  // classified item handed from the front end to the back end
  typedef struct packed {
    sample_t sample;
    logic    last;
    logic    emit;
    seen_t   seen;
    half_t   half;
    half_t   trail;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADJ,
    BK_ADJ_WAIT,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

endpackage

// ----- hdl/cma_channels.sv -----
`timescale 1ns / 1ps

// sample channel
interface cma_in_if;
  import cma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink (input valid, input sample, input is_last, output ready);
endinterface

// result channel
interface cma_out_if;
  import cma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t average;
  logic    end_of_record;

  modport source (output valid, output average, output end_of_record, input ready);
  modport sink (input valid, input average, input end_of_record, output ready);
endinterface

// ----- hdl/centered_moving_average.sv -----
`timescale 1ns / 1ps

// channel    direction  payload                    handshake
// in_chan    in         sample[15:0], is_last      valid / ready
// out_chan   out        average[15:0], end_of_record valid / ready
// cfg        in         cfg_data[4:0] half_window  cfg_we, no wait
//
// The back end stores a sample, moves samples one at a time in or out of
// the running window (at most one in steady state), starts the shared
// bit-serial divider, waits for it and loads the output register, the
// divider setting the pace. A final sample gives up to half_window + 1
// results; a sample with no result is only stored.
// Reset is synchronous; the sample ring needs no clearing pass.
// A two-entry queue and the output register let either side stall alone.

module centered_moving_average (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  cma_pkg::half_t cfg_data,
  cma_in_if.sink         in_chan,
  cma_out_if.source      out_chan
);
  import cma_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  cma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  cma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  cma_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_chan (out_chan)
  );

endmodule

// ----- hdl/cma_ram.sv -----
`timescale 1ns / 1ps

module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/cma_div.sv -----
`timescale 1ns / 1ps

module cma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cma_pkg::sum_t     dividend,
  input  cma_pkg::count_t   divisor,
  output logic              done,
  output cma_pkg::sample_t  quotient
);
  import cma_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     q_r, q_nxt;
  count_t               rem_r, rem_nxt;
  count_t               dsr_r, dsr_nxt;
  logic                 neg_r, neg_nxt;
  logic [COUNT_W:0]     rem_sh;
  logic [SUM_W-1:0]     signed_q;

  // one quotient bit per cycle, restoring, on the magnitude
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    if (start) begin
      neg_nxt  = dividend[SUM_W-1];
      q_nxt    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = COUNT_W'(rem_sh - {1'b0, dsr_r});
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = COUNT_W'(rem_sh);
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  // restore the sign, truncation toward zero falls out of magnitude division
  assign signed_q = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = sample_t'(signed_q[SAMPLE_W-1:0]);
  assign done     = done_r;

endmodule

// ----- hdl/cma_queue.sv -----
`timescale 1ns / 1ps

module cma_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cma_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cma_pkg::cmd_t  pop_data
);
  import cma_pkg::*;

  cmd_t                entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign push_ready = (fill_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/cma_front.sv -----
`timescale 1ns / 1ps

module cma_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  cma_pkg::half_t cfg_data,
  cma_in_if.sink         in_chan,
  output logic           push_valid,
  input  logic           push_ready,
  output cma_pkg::cmd_t  push_data
);
  import cma_pkg::*;

  half_t half_r, half_nxt;
  seen_t seen_r, seen_nxt;
  seen_t seen_now;
  seen_t seen_m1;
  logic  accept;

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;
  assign accept        = in_chan.valid & push_ready;

  // classify the item: running count, whether it emits, first trail length
  always_comb begin
    seen_now = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
    seen_m1  = seen_now - 1'b1;
    push_data.sample = in_chan.sample;
    push_data.last   = in_chan.is_last;
    push_data.seen   = seen_now;
    push_data.half   = half_r;
    push_data.emit   = in_chan.is_last | (seen_now > SEEN_W'(half_r));
    if (in_chan.is_last && (seen_m1 < SEEN_W'(half_r))) begin
      push_data.trail = HALF_W'(seen_m1);
    end else begin
      push_data.trail = half_r;
    end
  end

  // half window register and per-record count
  always_comb begin
    half_nxt = half_r;
    seen_nxt = seen_r;
    if (cfg_we) begin
      half_nxt = (cfg_data > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : cfg_data;
    end
    if (accept) begin
      seen_nxt = in_chan.is_last ? '0 : seen_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_W'(HALF_RESET);
      seen_r <= '0;
    end else begin
      half_r <= half_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- hdl/cma_back.sv -----
`timescale 1ns / 1ps

module cma_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  cma_pkg::cmd_t  pop_data,
  cma_out_if.source      out_chan
);
  import cma_pkg::*;

  bk_state_t  state_r, state_nxt;
  logic       last_r, last_nxt;
  seen_t      seen_r, seen_nxt;
  half_t      half_r, half_nxt;
  half_t      trail_r, trail_nxt;
  ring_addr_t wi_r, wi_nxt;
  count_t     held_r, held_nxt;
  sum_t       sum_r, sum_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_avg_r, out_avg_nxt;
  logic       out_eor_r, out_eor_nxt;

  seen_t      pos;
  seen_t      left;
  count_t     target;
  logic       grow;
  logic       at_target;
  logic       slot_free;
  ring_addr_t rd_addr;
  logic       ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;
  sample_t    old_sample;
  logic       div_start;
  logic       div_done;
  sample_t    div_q;

  // window length for the position with trail_r samples after it
  always_comb begin
    pos       = seen_r - 1'b1 - SEEN_W'(trail_r);
    left      = (pos < SEEN_W'(half_r)) ? pos : SEEN_W'(half_r);
    target    = COUNT_W'(left) + COUNT_W'(trail_r) + COUNT_W'(1);
    grow      = held_r < target;
    at_target = held_r == target;
    rd_addr   = grow ? (wi_r - RING_AW'(held_r) - 1'b1) : (wi_r - RING_AW'(held_r));
  end

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign pop_ready  = (state_r == BK_IDLE);
  assign ram_we     = (state_r == BK_IDLE) && pop_valid;
  assign div_start  = (state_r == BK_ADJ) && at_target;
  assign old_sample = sample_t'(ram_rdata);

  cma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wi_r),
    .wdata(pop_data.sample),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  cma_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_r),
    .divisor (target),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid && pop_data.emit) begin
          state_nxt = BK_ADJ;
        end
      end
      BK_ADJ: begin
        state_nxt = at_target ? BK_DIV : BK_ADJ_WAIT;
      end
      BK_ADJ_WAIT: begin
        state_nxt = BK_ADJ;
      end
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_nxt = (last_r && (trail_r != '0)) ? BK_ADJ : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    half_nxt      = half_r;
    trail_nxt     = trail_r;
    wi_nxt        = wi_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_avg_nxt   = out_avg_r;
    out_eor_nxt   = out_eor_r;
    case (state_r)
      BK_IDLE: begin
        // store the sample and extend the running window by it
        if (pop_valid) begin
          last_nxt  = pop_data.last;
          seen_nxt  = pop_data.seen;
          half_nxt  = pop_data.half;
          trail_nxt = pop_data.trail;
          wi_nxt    = wi_r + 1'b1;
          held_nxt  = held_r + 1'b1;
          sum_nxt   = sum_r + sum_t'(pop_data.sample);
        end
      end
      BK_ADJ_WAIT: begin
        // one sample in or out at the old end of the window
        if (grow) begin
          sum_nxt  = sum_r + sum_t'(old_sample);
          held_nxt = held_r + 1'b1;
        end else begin
          sum_nxt  = sum_r - sum_t'(old_sample);
          held_nxt = held_r - 1'b1;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = div_q;
          out_eor_nxt   = last_r && (trail_r == '0);
          if (last_r) begin
            if (trail_r != '0) begin
              trail_nxt = trail_r - 1'b1;
            end else begin
              wi_nxt   = '0;
              held_nxt = '0;
              sum_nxt  = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wi_r        <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wi_r        <= wi_nxt;
      held_r      <= held_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r    <= last_nxt;
    seen_r    <= seen_nxt;
    half_r    <= half_nxt;
    trail_r   <= trail_nxt;
    out_avg_r <= out_avg_nxt;
    out_eor_r <= out_eor_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.average       = out_avg_r;
  assign out_chan.end_of_record = out_eor_r;

endmodule

// ----- hdl/cma_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cma_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_is_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [cma_pkg::SAMPLE_W-1:0] out_average,
  input logic                   out_eor
);
  import cma_pkg::*;

  logic [2:0] open_r, open_nxt;
  logic       last_in, eor_out;

  // records whose final sample went in but whose closing result is not out
  assign last_in = in_valid && in_ready && in_is_last;
  assign eor_out = out_valid && out_ready && out_eor;

  always_comb begin
    open_nxt = open_r;
    if (last_in && !eor_out && (open_r != '1)) begin
      open_nxt = open_r + 1'b1;
    end else if (eor_out && !last_in && (open_r != '0)) begin
      open_nxt = open_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  `CMA_ASSERT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CMA_ASSERT(a_out_data_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_average) && $stable(out_eor), "result changed while stalled")
  `CMA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `CMA_ASSERT(a_eor_after_last, clk, rst_n, eor_out |-> open_r != '0, "end of record with no final sample taken")

endmodule

bind centered_moving_average cma_checker u_cma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_is_last (in_chan.is_last),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_average(out_chan.average),
  .out_eor    (out_chan.end_of_record)
);
